// ===== hdl/pbt_pkg.sv =====
// Package for the packet receipt bitmap tracker.
// Holds the item structs, opcode and state enums, register indexes and sizing constants.
// Depends on nothing; every other file but pbt_ram imports it.
`default_nettype none

package pbt_pkg;

    // Sizing of the bitmap and the limits on packets and the missing list
    localparam int MAX_PACKETS       = 2048;
    localparam int MAX_LENGTH        = 200;
    localparam int MAX_MISSING_BYTES = 100;

    localparam int WORD_W       = 32;
    localparam int BIT_IDX_W    = $clog2(WORD_W);
    localparam int BITMAP_WORDS = (MAX_PACKETS + WORD_W - 1) / WORD_W;
    localparam int WORD_IDX_W   = $clog2(BITMAP_WORDS);
    localparam int ID_W         = $clog2(MAX_PACKETS);

    // Field widths
    localparam int COUNT_W    = 12;
    localparam int SIZE_W     = 8;
    localparam int ADDR_W     = 32;
    localparam int PKT_ID_W   = 16;
    localparam int LEN_W      = 8;
    localparam int BYTES_W    = 7;
    localparam int PROD_W     = PKT_ID_W + SIZE_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PACKET_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PACKET_SIZE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDRESS = 2'd2;

    typedef enum logic [1:0] {
        OP_CLEAR   = 2'd0,
        OP_ARRIVAL = 2'd1,
        OP_CHECK   = 2'd2
    } t_opcode;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLEAR,
        S_ARRIVE,
        S_SCAN,
        S_FLUSH
    } t_state;

    typedef struct packed {
        logic [1:0]          opcode;
        logic [PKT_ID_W-1:0] packet_id;
        logic [LEN_W-1:0]    length;
        logic                write_ok;
    } t_in_item;

    typedef struct packed {
        logic               accepted;
        logic               write_needed;
        logic [ADDR_W-1:0]  write_address;
        logic [ID_W-1:0]    missing_id;
        logic [BYTES_W-1:0] missing_bytes;
        logic               all_received;
        logic               last;
    } t_out_item;

endpackage

`default_nettype wire

// ===== hdl/pbt_ram.sv =====
// Generic single-port-write, single-port-read synchronous RAM.
// Read data is registered and holds while the read enable is low. No dependencies.
`default_nettype none

module pbt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== hdl/packet_receipt_bitmap_tracker_top.sv =====
// Channel   | valid    | ready    | payload
// ----------+----------+----------+-----------------------------------------
// request   | i_valid  | o_ready  | i_item (t_in_item)
// result    | o_valid  | i_ready  | o_item (t_out_item)
// config    | i_cfg_we | (none)   | i_cfg_index, i_cfg_data
//
// One item is worked on at a time. A clear drops the per-word valid bits when accepted;
// for a packet arrival the bitmap word is read in the accept cycle and modified and
// written back once the result register is free. A check walks the bitmap words up to
// the packet count, emits at most 51 missing ids; the single bitmap read port sets the pace.
// Reset clears the per-word valid bits, so the bitmap reads as empty at once; a
// stalled result holds the block as soon as it has another result to load.
// Depends on pbt_pkg and pbt_ram.
`default_nettype none

module packet_receipt_bitmap_tracker_top
    import pbt_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire t_in_item              i_item,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output t_out_item                  o_item,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_state r_state, n_state;

    // Configuration registers
    logic [COUNT_W-1:0] r_cfg_count;
    logic [SIZE_W-1:0]  r_cfg_size;
    logic [ADDR_W-1:0]  r_cfg_base;

    // Bitmap memory and its per-word valid bits
    logic [BITMAP_WORDS-1:0] r_valid, n_valid;
    logic                    ram_we, ram_re;
    logic [WORD_IDX_W-1:0]   ram_waddr, ram_raddr;
    logic [WORD_W-1:0]       ram_wdata, ram_rdata;

    // Item and scan registers
    t_in_item            r_item, n_item;
    logic [PROD_W-1:0]   r_prod, n_prod;
    logic [WORD_IDX_W-1:0] r_idx, n_idx;
    logic [WORD_W-1:0]   r_done, n_done;
    logic                r_hold_valid, n_hold_valid;
    logic [ID_W-1:0]     r_hold_id, n_hold_id;
    logic [BYTES_W-1:0]  r_bytes, n_bytes;

    // Output register
    logic      r_out_valid, n_out_valid;
    t_out_item r_out, n_out;

    // Shared decode
    logic                  in_accept, out_free;
    logic [COUNT_W-1:0]    eff_count;
    logic [ID_W-1:0]       last_id;
    logic [WORD_IDX_W-1:0] last_word;
    logic [BIT_IDX_W-1:0]  last_bit;
    logic [WORD_IDX_W-1:0] arr_widx;
    logic [WORD_W-1:0]     arr_word, scan_word, scan_lim, miss;
    logic                  arr_reject, arr_dup, found;
    logic [BIT_IDX_W-1:0]  low_bit;
    logic [BYTES_W-1:0]    new_bytes;
    logic                  scan_take;

    assign o_ready   = (r_state == S_IDLE);
    assign in_accept = i_valid && o_ready;
    assign out_free  = !r_out_valid || i_ready;
    assign o_valid   = r_out_valid;
    assign o_item    = r_out;

    // Packet count saturated to the bitmap size
    assign eff_count = (r_cfg_count > COUNT_W'(MAX_PACKETS)) ? COUNT_W'(MAX_PACKETS)
                                                             : r_cfg_count;
    assign last_id   = ID_W'(eff_count - COUNT_W'(1));
    assign last_word = last_id[ID_W-1:BIT_IDX_W];
    assign last_bit  = last_id[BIT_IDX_W-1:0];

    // Arrival: check the range and look up the stored bit
    assign arr_widx   = r_item.packet_id[ID_W-1:BIT_IDX_W];
    assign arr_word   = r_valid[arr_widx] ? ram_rdata : '0;
    assign arr_reject = (r_item.packet_id >= PKT_ID_W'(eff_count))
                     || (r_item.length > LEN_W'(MAX_LENGTH));
    assign arr_dup    = arr_word[r_item.packet_id[BIT_IDX_W-1:0]];

    // Check: missing bits of the current word not yet emitted
    assign scan_word = r_valid[r_idx] ? ram_rdata : '0;
    assign scan_lim  = (r_idx == last_word) ? ({WORD_W{1'b1}} >> (BIT_IDX_W'(WORD_W - 1) - last_bit))
                                            : {WORD_W{1'b1}};
    assign miss      = ~scan_word & scan_lim & ~r_done;
    assign found     = |miss;
    assign new_bytes = r_bytes + BYTES_W'(2);
    assign scan_take = found && (!r_hold_valid || out_free);

    // Lowest missing bit
    always_comb begin
        low_bit = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (miss[i]) begin
                low_bit = BIT_IDX_W'(i);
            end
        end
    end

    // Bitmap memory
    pbt_ram #(
        .WIDTH (WORD_W),
        .DEPTH (BITMAP_WORDS)
    ) u_bitmap (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    case (i_item.opcode)
                        OP_CLEAR:   n_state = S_CLEAR;
                        OP_ARRIVAL: n_state = S_ARRIVE;
                        OP_CHECK:   n_state = (eff_count == '0) ? S_FLUSH : S_SCAN;
                        default:    n_state = S_IDLE;
                    endcase
                end
            end
            S_CLEAR, S_ARRIVE, S_FLUSH: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_SCAN: begin
                if (found) begin
                    if (scan_take && (new_bytes > BYTES_W'(MAX_MISSING_BYTES))) begin
                        n_state = S_FLUSH;
                    end
                end else if (r_idx == last_word) begin
                    n_state = S_FLUSH;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath, memory and result register
    always_comb begin
        n_valid      = r_valid;
        n_item       = r_item;
        n_prod       = r_prod;
        n_idx        = r_idx;
        n_done       = r_done;
        n_hold_valid = r_hold_valid;
        n_hold_id    = r_hold_id;
        n_bytes      = r_bytes;
        n_out_valid  = r_out_valid && !i_ready;
        n_out        = r_out;
        ram_we       = 1'b0;
        ram_waddr    = arr_widx;
        ram_wdata    = arr_word | (WORD_W'(1) << r_item.packet_id[BIT_IDX_W-1:0]);
        ram_re       = 1'b0;
        ram_raddr    = r_idx + WORD_IDX_W'(1);

        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_item       = i_item;
                    n_prod       = PROD_W'(i_item.packet_id) * PROD_W'(r_cfg_size);
                    n_idx        = '0;
                    n_done       = '0;
                    n_hold_valid = 1'b0;
                    n_bytes      = '0;
                    case (i_item.opcode)
                        OP_CLEAR: begin
                            n_valid = '0;
                        end
                        OP_ARRIVAL: begin
                            ram_re    = 1'b1;
                            ram_raddr = i_item.packet_id[ID_W-1:BIT_IDX_W];
                        end
                        OP_CHECK: begin
                            ram_re    = 1'b1;
                            ram_raddr = '0;
                        end
                        default: ;
                    endcase
                end
            end
            S_CLEAR: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = '0;
                    n_out.accepted = 1'b1;
                    n_out.last     = 1'b1;
                end
            end
            S_ARRIVE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = '0;
                    n_out.last  = 1'b1;
                    if (!arr_reject) begin
                        if (arr_dup) begin
                            n_out.accepted = 1'b1;
                        end else begin
                            n_out.accepted      = r_item.write_ok;
                            n_out.write_needed  = 1'b1;
                            n_out.write_address = r_cfg_base + ADDR_W'(r_prod);
                            if (r_item.write_ok) begin
                                ram_we            = 1'b1;
                                n_valid[arr_widx] = 1'b1;
                            end
                        end
                    end
                end
            end
            S_SCAN: begin
                if (found) begin
                    if (scan_take) begin
                        // Emit the held id with its running count, then hold the new one
                        if (r_hold_valid) begin
                            n_out_valid         = 1'b1;
                            n_out               = '0;
                            n_out.missing_id    = r_hold_id;
                            n_out.missing_bytes = r_bytes;
                        end
                        n_hold_valid     = 1'b1;
                        n_hold_id        = {r_idx, low_bit};
                        n_bytes          = new_bytes;
                        n_done[low_bit]  = 1'b1;
                    end
                end else if (r_idx != last_word) begin
                    // Move to the next bitmap word
                    ram_re = 1'b1;
                    n_idx  = r_idx + WORD_IDX_W'(1);
                    n_done = '0;
                end
            end
            S_FLUSH: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = '0;
                    n_out.last  = 1'b1;
                    if (r_hold_valid) begin
                        n_out.missing_id    = r_hold_id;
                        n_out.missing_bytes = r_bytes;
                    end else begin
                        n_out.accepted     = 1'b1;
                        n_out.all_received = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_valid      <= '0;
            r_hold_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_valid      <= n_valid;
            r_hold_valid <= n_hold_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_item    <= n_item;
        r_prod    <= n_prod;
        r_idx     <= n_idx;
        r_done    <= n_done;
        r_hold_id <= n_hold_id;
        r_bytes   <= n_bytes;
        r_out     <= n_out;
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_count <= '0;
            r_cfg_size  <= '0;
            r_cfg_base  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_PACKET_COUNT: r_cfg_count <= i_cfg_data[COUNT_W-1:0];
                CFG_PACKET_SIZE:  r_cfg_size  <= i_cfg_data[SIZE_W-1:0];
                CFG_BASE_ADDRESS: r_cfg_base  <= i_cfg_data[ADDR_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== hdl/pbt_checker.sv =====
// Port-level checker for the packet receipt bitmap tracker, bound to the top level.
// Depends on pbt_pkg; the bind statement at the end attaches it.
`default_nettype none

module pbt_checker
    import pbt_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_valid,
    input wire logic      o_ready,
    input wire t_in_item  i_item,
    input wire logic      o_valid,
    input wire logic      i_ready,
    input wire t_out_item o_item
);

    // A result item waiting to be taken stays, unchanged
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_item))
        else $error("result item changed while stalled");

    // One item at a time: an accepted item with a known opcode blocks the next one
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && ((i_item.opcode == OP_CLEAR) || (i_item.opcode == OP_ARRIVAL)
            || (i_item.opcode == OP_CHECK)) |=> !o_ready)
        else $error("new item taken right after an accepted one");

    // A report of nothing missing is final and carries no list
    a_all_received: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_item.all_received |->
            o_item.accepted && o_item.last && (o_item.missing_bytes == '0))
        else $error("malformed all-received result");

    // A write request is a single final result with no missing-list content
    a_write_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_item.write_needed |->
            o_item.last && !o_item.all_received && (o_item.missing_bytes == '0))
        else $error("malformed write result");

    // Missing-list entries are even, bounded and never marked accepted
    a_missing_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_item.missing_bytes != '0) |->
            !o_item.accepted && !o_item.missing_bytes[0]
            && (o_item.missing_bytes <= BYTES_W'(MAX_MISSING_BYTES + 2)))
        else $error("malformed missing-list entry");

endmodule

bind packet_receipt_bitmap_tracker_top pbt_checker u_pbt_checker (.*);

`default_nettype wire

// ===== tb/sv/pbt_reply_checker.sv =====
// Reply checker for the packet receipt bitmap tracker: snoops the register port and
// both item channels, works out the replies each accepted request owes and compares them.
// Depends on pbt_pkg for the item structs, opcodes, register indexes and sizes.
module pbt_reply_checker
    import pbt_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_req_valid,
    input  wire logic                  i_req_ready,
    input  wire t_in_item              i_req_item,
    input  wire logic                  i_res_valid,
    input  wire logic                  i_res_ready,
    input  wire t_out_item             i_res_item,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                         o_fail_count,
    output int                         o_replies_due,
    output int                         o_replies_seen,
    output int                         o_complete_scans
);
    timeunit 1ns;
    timeprecision 1ps;

    // Our own copy of the tracker: register values and one bit per stored packet.
    logic [COUNT_W-1:0]     cfg_count;
    logic [SIZE_W-1:0]      cfg_size;
    logic [ADDR_W-1:0]      cfg_base;
    logic [MAX_PACKETS-1:0] stored_ids;
    t_out_item              replies_due[$];

    initial begin
        o_fail_count     = 0;
        o_replies_due    = 0;
        o_replies_seen   = 0;
        o_complete_scans = 0;
    end

    function automatic string show_reply(input t_out_item r);
        return $sformatf("acc=%0d wn=%0d addr=%h mid=%0d mbytes=%0d all=%0d last=%0d",
                         r.accepted, r.write_needed, r.write_address, r.missing_id,
                         r.missing_bytes, r.all_received, r.last);
    endfunction

    // Work out every reply that one accepted request causes and queue them in order.
    task automatic work_out_replies(input t_in_item req);
        t_out_item r;
        t_out_item tail;
        int        live_count;
        int        id;
        int        bytes;
        int        n;
        live_count = (int'(cfg_count) > MAX_PACKETS) ? MAX_PACKETS : int'(cfg_count);
        id         = int'(req.packet_id);
        r          = '0;
        r.last     = 1'b1;
        case (req.opcode)
            OP_CLEAR: begin
                stored_ids = '0;
                r.accepted = 1'b1;
                replies_due.push_back(r);
            end
            OP_ARRIVAL: begin
                if (id >= live_count || int'(req.length) > MAX_LENGTH) begin
                    // Bad id or over-long packet: everything but last stays low.
                end else if (stored_ids[id]) begin
                    r.accepted = 1'b1;
                end else begin
                    r.accepted      = req.write_ok;
                    r.write_needed  = 1'b1;
                    r.write_address = ADDR_W'(id * int'(cfg_size)) + cfg_base;
                    if (req.write_ok) begin
                        stored_ids[id] = 1'b1;
                    end
                end
                replies_due.push_back(r);
            end
            OP_CHECK: begin
                // Walk the ids upwards, one reply per gap, until the list is too long.
                bytes  = 0;
                n      = 0;
                r.last = 1'b0;
                for (int i = 0; i < live_count; i++) begin
                    if (!stored_ids[i]) begin
                        bytes          += 2;
                        r.missing_id    = ID_W'(i);
                        r.missing_bytes = BYTES_W'(bytes);
                        replies_due.push_back(r);
                        n++;
                        if (bytes > MAX_MISSING_BYTES) begin
                            break;
                        end
                    end
                end
                if (n == 0) begin
                    r              = '0;
                    r.accepted     = 1'b1;
                    r.all_received = 1'b1;
                    r.last         = 1'b1;
                    replies_due.push_back(r);
                    o_complete_scans++;
                end else begin
                    tail      = replies_due.pop_back();
                    tail.last = 1'b1;
                    replies_due.push_back(tail);
                end
            end
            default: begin
                // The spare opcode is dropped without a reply.
            end
        endcase
    endtask

    // Compare one reply from the block with the oldest one still owed.
    task automatic check_reply(input t_out_item got);
        t_out_item want;
        logic      bad;
        o_replies_seen++;
        if (replies_due.size() == 0) begin
            o_fail_count++;
            if (o_fail_count <= 10) begin
                $display("reply %0d arrived with nothing owed: %s", o_replies_seen,
                         show_reply(got));
            end
        end else begin
            want = replies_due.pop_front();
            bad  = (got.accepted !== want.accepted) ||
                   (got.write_needed !== want.write_needed) ||
                   (got.write_address !== want.write_address) ||
                   (got.missing_id !== want.missing_id) ||
                   (got.missing_bytes !== want.missing_bytes) ||
                   (got.all_received !== want.all_received) ||
                   (got.last !== want.last);
            if (bad) begin
                o_fail_count++;
                if (o_fail_count <= 10) begin
                    $display("reply %0d mismatch", o_replies_seen);
                    $display("  expected %s", show_reply(want));
                    $display("  actual   %s", show_reply(got));
                end
            end
        end
    endtask

    // Everything is sampled at the rising edge, before the edge's updates land.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_count  = '0;
            cfg_size   = '0;
            cfg_base   = '0;
            stored_ids = '0;
            replies_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_PACKET_COUNT: cfg_count = i_cfg_data[COUNT_W-1:0];
                    CFG_PACKET_SIZE:  cfg_size  = i_cfg_data[SIZE_W-1:0];
                    CFG_BASE_ADDRESS: cfg_base  = i_cfg_data[ADDR_W-1:0];
                    default: ;
                endcase
            end
            if (i_res_valid && i_res_ready) begin
                check_reply(i_res_item);
            end
            if (i_req_valid && i_req_ready) begin
                work_out_replies(i_req_item);
            end
        end
        o_replies_due = replies_due.size();
    end

endmodule

// ===== tb/sv/testbench.sv =====
// Top of the bench for the packet receipt bitmap tracker: clock, reset, register setup,
// request stimulus with random gaps, a stalling result sink and the final verdict.
// Depends on pbt_pkg, packet_receipt_bitmap_tracker_top and pbt_reply_checker.
module testbench
    import pbt_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    // Spare codes that the block has no name for.
    localparam logic [1:0]           OP_UNUSED  = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    // Longest check walks 64 bitmap words and emits 51 replies.
    localparam int SETTLE_CYCLES = 128;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_valid     = 1'b0;
    logic                  o_ready;
    t_in_item              i_item      = '0;
    logic                  o_valid;
    logic                  i_ready     = 1'b0;
    t_out_item             o_item;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    int fail_count;
    int replies_due;
    int replies_seen;
    int complete_scans;

    int             requests_sent = 0;
    int             settings_used = 0;
    bit             calm          = 1'b0;
    logic [COUNT_W-1:0] cur_count = '0;

    always #4 i_clk = ~i_clk;

    packet_receipt_bitmap_tracker_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_item      (i_item),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_item      (o_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    pbt_reply_checker u_check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_req_valid      (i_valid),
        .i_req_ready      (o_ready),
        .i_req_item       (i_item),
        .i_res_valid      (o_valid),
        .i_res_ready      (i_ready),
        .i_res_item       (o_item),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_fail_count     (fail_count),
        .o_replies_due    (replies_due),
        .o_replies_seen   (replies_seen),
        .o_complete_scans (complete_scans)
    );

    // Gap length in cycles: mostly none or short, now and then a long one.
    function automatic int idle_gap();
        int r;
        if (calm) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end else if (r < 98) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic t_in_item make_item(input logic [1:0] op, input int id, input int len,
                                           input bit ok);
        t_in_item it;
        it.opcode    = op;
        it.packet_id = PKT_ID_W'(id);
        it.length    = LEN_W'(len);
        it.write_ok  = ok;
        return it;
    endfunction

    function automatic int live_count();
        return (int'(cur_count) > MAX_PACKETS) ? MAX_PACKETS : int'(cur_count);
    endfunction

    // Ids mostly inside the image, some at its edge, some anywhere in the field.
    function automatic int pick_id();
        int r;
        int cnt;
        r   = $urandom_range(0, 99);
        cnt = live_count();
        if (r < 10) begin
            return $urandom_range(0, 65535);
        end else if (r < 20) begin
            return (cnt == 0) ? $urandom_range(0, 2) : cnt - 1 + $urandom_range(0, 2);
        end else if (r < 60 && cnt > 160) begin
            return $urandom_range(0, 159);
        end
        return (cnt == 0) ? $urandom_range(0, 3) : $urandom_range(0, cnt - 1);
    endfunction

    function automatic t_in_item random_item();
        int r;
        int len;
        r   = $urandom_range(0, 99);
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(MAX_LENGTH + 1, 255)
                                          : $urandom_range(0, MAX_LENGTH);
        if (r < 70) begin
            return make_item(OP_ARRIVAL, pick_id(), len, $urandom_range(0, 5) != 0);
        end else if (r < 84) begin
            return make_item(OP_CHECK, $urandom_range(0, 65535), $urandom_range(0, 255),
                             $urandom_range(0, 1));
        end else if (r < 93) begin
            return make_item(OP_CLEAR, $urandom_range(0, 65535), $urandom_range(0, 255),
                             $urandom_range(0, 1));
        end
        return make_item(OP_UNUSED, $urandom_range(0, 65535), $urandom_range(0, 255),
                         $urandom_range(0, 1));
    endfunction

    // Offer one request and hold it until the block takes it. Valid is left high so
    // that a back-to-back request needs no second assignment in the same step.
    task automatic send(input t_in_item it);
        int gap;
        gap = idle_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_item  <= it;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        if (it.opcode != OP_UNUSED) begin
            requests_sent++;
        end
    endtask

    // Stop offering requests and wait until every owed reply is in and the block is quiet.
    task automatic settle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (replies_due != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Register writes on consecutive edges; the enable drops only after the last one.
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        @(posedge i_clk);
    endtask

    task automatic configure(input logic [COUNT_W-1:0] count, input logic [SIZE_W-1:0] size,
                             input logic [ADDR_W-1:0] base, input bit poke_spare);
        // Upper data bits are junk that the block must ignore.
        cfg_write(CFG_PACKET_COUNT, ($urandom() & 32'hFFFF_F000) | 32'(count));
        cfg_write(CFG_PACKET_SIZE, ($urandom() & 32'hFFFF_FF00) | 32'(size));
        cfg_write(CFG_BASE_ADDRESS, base);
        if (poke_spare) begin
            cfg_write(CFG_UNUSED, $urandom());
        end
        i_cfg_we  <= 1'b0;
        cur_count  = count;
        settings_used++;
    endtask

    // Mix of runs of good arrivals over neighbouring ids, each run often closed by a
    // check, and single random requests of every kind.
    task automatic random_phase(input int n_items);
        int       done;
        int       start;
        int       run;
        int       cnt;
        t_in_item it;
        done = 0;
        while (done < n_items) begin
            cnt = live_count();
            if ($urandom_range(0, 99) < 55) begin
                start = (cnt == 0) ? 0 : $urandom_range(0, cnt - 1);
                run   = $urandom_range(1, 24);
                for (int k = 0; k < run; k++) begin
                    send(make_item(OP_ARRIVAL, (cnt == 0) ? k : (start + k) % cnt,
                                   $urandom_range(0, MAX_LENGTH),
                                   $urandom_range(0, 9) != 0));
                    done++;
                end
                if ($urandom_range(0, 1) == 1) begin
                    send(make_item(OP_CHECK, 0, 0, 1'b0));
                    done++;
                end
            end else begin
                it = random_item();
                send(it);
                if (it.opcode != OP_UNUSED) begin
                    done++;
                end
            end
        end
    endtask

    // Result sink: bursts of ready broken by random stalls.
    initial begin : result_sink
        int gap;
        forever begin
            gap = idle_gap();
            if (gap > 0) begin
                i_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    end

    initial begin : stimulus
        logic [COUNT_W-1:0] count;
        logic [SIZE_W-1:0]  size;
        logic [ADDR_W-1:0]  base;
        int                 r;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Forty packets, largest size and a base that makes the address wrap.
        configure(12'd40, 8'd255, 32'hFFFF_FF00, 1'b0);
        send(make_item(OP_CHECK, 0, 0, 1'b0));
        send(make_item(OP_ARRIVAL, 0, 0, 1'b1));
        send(make_item(OP_ARRIVAL, 0, MAX_LENGTH, 1'b1));
        send(make_item(OP_ARRIVAL, 39, MAX_LENGTH, 1'b0));
        send(make_item(OP_ARRIVAL, 39, MAX_LENGTH, 1'b1));
        send(make_item(OP_ARRIVAL, 40, 10, 1'b1));
        send(make_item(OP_ARRIVAL, 65535, 255, 1'b1));
        send(make_item(OP_ARRIVAL, 1, MAX_LENGTH + 1, 1'b1));
        send(make_item(OP_UNUSED, 16'hAAAA, 8'h55, 1'b1));
        send(make_item(OP_CHECK, 65535, 255, 1'b1));
        send(make_item(OP_CLEAR, 0, 0, 1'b0));
        send(make_item(OP_CHECK, 0, 0, 1'b0));
        settle();

        // An empty image rejects every id and is always complete.
        configure(12'd0, 8'h5A, 32'h0000_0000, 1'b1);
        send(make_item(OP_ARRIVAL, 0, 0, 1'b1));
        send(make_item(OP_CHECK, 0, 0, 1'b0));
        settle();

        // Two packets, both stored, then a complete check and a duplicate.
        configure(12'd2, 8'd1, 32'h0000_1000, 1'b0);
        send(make_item(OP_ARRIVAL, 0, 5, 1'b1));
        send(make_item(OP_ARRIVAL, 1, 5, 1'b1));
        send(make_item(OP_CHECK, 0, 0, 1'b0));
        send(make_item(OP_ARRIVAL, 1, 5, 1'b1));
        settle();

        // Count above the bitmap size saturates; the missing list gets cut short.
        configure(12'hFFF, 8'd0, 32'hFFFF_FFFF, 1'b0);
        send(make_item(OP_ARRIVAL, MAX_PACKETS - 1, MAX_LENGTH, 1'b1));
        send(make_item(OP_ARRIVAL, MAX_PACKETS, 0, 1'b1));
        send(make_item(OP_CHECK, 0, 0, 1'b0));
        send(make_item(OP_ARRIVAL, 65535, 0, 1'b1));
        settle();

        configure(12'd2048, 8'd255, 32'h0000_0000, 1'b0);
        send(make_item(OP_ARRIVAL, MAX_PACKETS - 1, 0, 1'b1));
        send(make_item(OP_CHECK, 0, 0, 1'b0));
        send(make_item(OP_CLEAR, 65535, 255, 1'b1));
        settle();

        // Random phases, each under its own register setting.
        for (int p = 0; p < 8; p++) begin
            case (p)
                0:       count = 12'd1;
                1:       count = 12'd5;
                2:       count = 12'd32;
                3:       count = 12'd33;
                4:       count = 12'd64;
                5:       count = COUNT_W'($urandom_range(65, 300));
                6:       count = 12'd2048;
                default: count = COUNT_W'($urandom_range(0, 4095));
            endcase
            r    = $urandom_range(0, 3);
            size = (r == 0) ? 8'd0 : (r == 1) ? 8'd255 : SIZE_W'($urandom_range(1, 254));
            r    = $urandom_range(0, 3);
            base = (r == 0) ? 32'h0 : (r == 1) ? 32'hFFFF_FFFF : $urandom();
            configure(count, size, base, p == 3);
            calm = (p == 2) || ($urandom_range(0, 3) == 0);
            random_phase(45);
            settle();
        end

        $display("summary: %0d requests under %0d register settings, %0d replies compared",
                 requests_sent, settings_used, replies_seen);
        $display("summary: %0d checks found every packet stored, %0d replies still owed",
                 complete_scans, replies_due);
        if (fail_count == 0 && replies_due == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Hard stop well beyond the slowest correct run.
    initial begin : watchdog
        #50ms;
        $display("tb: failure");
        $finish;
    end

endmodule
